// ===== hdl/bafl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bafl_pkg: shared definitions of the bump allocator with free list
// Sizes, widths, register indexes, status codes and the shared adder types.
// ----------------------------------------------------------------------------
package bafl_pkg;

  // Allocator geometry (ALIGN_BYTES must be a power of two)
  localparam int FREE_DEPTH   = 16;
  localparam int HEAP_BYTES   = 64 * 1024;
  localparam int HEADER_BYTES = 8;
  localparam int ALIGN_BYTES  = 4;

  // Register reset values
  localparam logic [31:0] HEAP_BASE_RST  = 32'h4800_0000;
  localparam logic [31:0] HEAP_LIMIT_RST = HEAP_BASE_RST + 32'(HEAP_BYTES);

  // Field widths
  localparam int ADDR_W = 32;
  localparam int SIZE_W = 16;

  // Derived widths
  localparam int FREE_IDX_W  = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(FREE_DEPTH + 1);
  localparam int ALIGN_SHIFT = $clog2(ALIGN_BYTES);
  localparam int SLOTS       = HEAP_BYTES / ALIGN_BYTES;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int FOFF_W      = $clog2(HEAP_BYTES);        // offset of a live header
  localparam int OFF_W       = $clog2(HEAP_BYTES + 1);    // bump offset, may reach the end
  localparam int TOT_W       = $clog2((2 ** SIZE_W) + HEADER_BYTES + ALIGN_BYTES);
  localparam int NEND_W      = ((OFF_W > TOT_W) ? OFF_W : TOT_W) + 1;
  localparam int ALU_W       = ADDR_W + 2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAP_BASE  = 2'd0,
    CFG_HEAP_LIMIT = 2'd1
  } cfg_idx_e;

  // Request kinds
  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_REUSED  = 3'd0,
    ST_BUMPED  = 3'd1,
    ST_OOM     = 3'd2,
    ST_FREED   = 3'd3,
    ST_IGNORED = 3'd4
  } status_e;

  // Shared adder operation and result
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             neg;
  } alu_rsp_t;

endpackage

// ===== hdl/bafl_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bafl_alu: shared add / subtract unit
// Adds or subtracts two zero-extended operands. With both operands below
// 2**(ALU_W-1), neg flags a < b on a subtract.
// ----------------------------------------------------------------------------
module bafl_alu import bafl_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [ALU_W-1:0] b_op;

  // Two's complement subtract: invert b and carry in one
  assign b_op      = req_i.sub ? ~req_i.b : req_i.b;
  assign rsp_o.sum = req_i.a + b_op + ALU_W'(req_i.sub);
  assign rsp_o.neg = rsp_o.sum[ALU_W-1];

endmodule

// ===== hdl/bump_allocator_first_fit_free_list_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bump_allocator_first_fit_free_list_unit: heap allocator, top level
// A free subtracts header and base from the address, checks the offset and pushes it onto the
// freed list; an allocation scans the list and on a fit moves later entries down, else bumps.
// One transaction at a time: a request is accepted only in idle, which is reached as the
// result becomes valid; a stalled result holds off input.
// Reset clears bump offset, free count and handshakes and loads the default heap
// base and limit; the size store and freed list are not cleared.
// ----------------------------------------------------------------------------
module bump_allocator_first_fit_free_list_unit import bafl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [SIZE_W-1:0]    req_size_i,
  input  logic [ADDR_W-1:0]    req_addr_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ADDR_W-1:0]    alloc_addr_o,
  output logic [2:0]           status_o,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [ADDR_W-1:0]    cfg_wdata_i
);

  typedef enum logic [12:0] {
    S_IDLE       = 13'b0000000000001,
    S_SCAN       = 13'b0000000000010,
    S_REUSE_ADDR = 13'b0000000000100,
    S_SHIFT      = 13'b0000000001000,
    S_BUMP_END   = 13'b0000000010000,
    S_BUMP_ABS   = 13'b0000000100000,
    S_BUMP_LIM   = 13'b0000001000000,
    S_BUMP_ADDR  = 13'b0000010000000,
    S_FREE_SUB1  = 13'b0000100000000,
    S_FREE_SUB2  = 13'b0001000000000,
    S_FREE_CHK   = 13'b0010000000000,
    S_FREE_PUSH  = 13'b0100000000000,
    S_EMIT       = 13'b1000000000000
  } state_e;

  // Control state
  state_e                state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [OFF_W-1:0]      bump_q, bump_d;
  logic [FREE_IDX_W-1:0] ptr_q, ptr_d;
  logic                  out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]     heap_base_q, heap_limit_q;

  // Payload and scratch
  logic [SIZE_W-1:0]     req_size_q, req_size_d;
  logic [ADDR_W-1:0]     req_addr_q, req_addr_d;
  logic [ADDR_W-1:0]     off_q, off_d;
  logic [NEND_W-1:0]     end_q, end_d;
  logic [ADDR_W:0]       abs_q, abs_d;
  logic [ADDR_W-1:0]     res_addr_q, res_addr_d;
  status_e               res_status_q, res_status_d;
  logic [ADDR_W-1:0]     out_addr_q, out_addr_d;
  status_e               out_status_q, out_status_d;

  // Freed list entries, oldest at index 0
  logic [FOFF_W-1:0]     free_off_q  [FREE_DEPTH];
  logic [SIZE_W-1:0]     free_size_q [FREE_DEPTH];
  logic                  ent_we;
  logic [FREE_IDX_W-1:0] ent_widx, rd_idx;
  logic [FOFF_W-1:0]     ent_woff;
  logic [SIZE_W-1:0]     ent_wsize;

  // Per-header size store
  logic [SIZE_W-1:0]     size_mem [SLOTS];
  logic                  ram_we, ram_re;
  logic [SLOT_W-1:0]     ram_waddr, ram_raddr;
  logic [SIZE_W-1:0]     ram_rdata_q;

  // Shared adder
  alu_req_t              alu_req;
  alu_rsp_t              alu_rsp;
  logic [TOT_W-1:0]      tot;
  logic                  free_ok;

  bafl_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Ports
  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign alloc_addr_o = out_addr_q;
  assign status_o     = out_status_q;
  assign cfg_ready_o  = 1'b1;

  // Block footprint: payload plus header, rounded up to the alignment
  assign tot = (TOT_W'(req_size_q) + TOT_W'(HEADER_BYTES + ALIGN_BYTES - 1))
             & ~TOT_W'(ALIGN_BYTES - 1);

  // Single read port of the freed list: the shift pass reads one above
  assign rd_idx    = (state_q == S_SHIFT) ? ptr_q + FREE_IDX_W'(1) : ptr_q;
  assign ram_waddr = bump_q[ALIGN_SHIFT +: SLOT_W];
  assign ram_raddr = off_q[ALIGN_SHIFT +: SLOT_W];

  // Free is legal: non-null, inside the bumped area, aligned, list not full
  assign free_ok = (req_addr_q != '0) && alu_rsp.neg
                && ((off_q & ADDR_W'(ALIGN_BYTES - 1)) == '0)
                && (cnt_q < CNT_W'(FREE_DEPTH));

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    bump_d       = bump_q;
    ptr_d        = ptr_q;
    out_valid_d  = out_valid_q;
    req_size_d   = req_size_q;
    req_addr_d   = req_addr_q;
    off_d        = off_q;
    end_d        = end_q;
    abs_d        = abs_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;
    alu_req      = '0;
    ent_we       = 1'b0;
    ent_widx     = ptr_q;
    ent_woff     = free_off_q[rd_idx];
    ent_wsize    = free_size_q[rd_idx];
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_size_d = req_size_i;
          req_addr_d = req_addr_i;
          if (req_type_i == REQ_FREE) begin
            state_d = S_FREE_SUB1;
          end else if (cnt_q == '0) begin
            state_d = S_BUMP_END;
          end else begin
            ptr_d   = FREE_IDX_W'(cnt_q - CNT_W'(1));
            state_d = S_SCAN;
          end
        end
      end

      // newest to oldest: entry size >= request
      S_SCAN: begin
        alu_req.a   = ALU_W'(free_size_q[rd_idx]);
        alu_req.b   = ALU_W'(req_size_q);
        alu_req.sub = 1'b1;
        if (!alu_rsp.neg) begin
          off_d   = ADDR_W'(free_off_q[rd_idx]);
          state_d = S_REUSE_ADDR;
        end else if (ptr_q == '0) begin
          state_d = S_BUMP_END;
        end else begin
          ptr_d = ptr_q - FREE_IDX_W'(1);
        end
      end

      S_REUSE_ADDR: begin
        alu_req.a    = ALU_W'(heap_base_q);
        alu_req.b    = ALU_W'(off_q) + ALU_W'(HEADER_BYTES);
        res_addr_d   = alu_rsp.sum[ADDR_W-1:0];
        res_status_d = ST_REUSED;
        state_d      = S_SHIFT;
      end

      // close the gap, one entry per cycle
      S_SHIFT: begin
        if ((CNT_W'(ptr_q) + CNT_W'(1)) < cnt_q) begin
          ent_we = 1'b1;
          ptr_d  = ptr_q + FREE_IDX_W'(1);
        end else begin
          cnt_d   = cnt_q - CNT_W'(1);
          state_d = S_EMIT;
        end
      end

      S_BUMP_END: begin
        alu_req.a = ALU_W'(bump_q);
        alu_req.b = ALU_W'(tot);
        end_d     = alu_rsp.sum[NEND_W-1:0];
        state_d   = S_BUMP_ABS;
      end

      S_BUMP_ABS: begin
        alu_req.a = ALU_W'(heap_base_q);
        alu_req.b = ALU_W'(end_q);
        abs_d     = alu_rsp.sum[ADDR_W:0];
        state_d   = S_BUMP_LIM;
      end

      // limit < absolute end, or past the heap size: out of memory
      S_BUMP_LIM: begin
        alu_req.a   = ALU_W'(heap_limit_q);
        alu_req.b   = ALU_W'(abs_q);
        alu_req.sub = 1'b1;
        if (alu_rsp.neg || (end_q > NEND_W'(HEAP_BYTES))) begin
          res_addr_d   = '0;
          res_status_d = ST_OOM;
          state_d      = S_EMIT;
        end else begin
          ram_we  = 1'b1;
          state_d = S_BUMP_ADDR;
        end
      end

      S_BUMP_ADDR: begin
        alu_req.a    = ALU_W'(heap_base_q);
        alu_req.b    = ALU_W'(bump_q) + ALU_W'(HEADER_BYTES);
        res_addr_d   = alu_rsp.sum[ADDR_W-1:0];
        res_status_d = ST_BUMPED;
        bump_d       = end_q[OFF_W-1:0];
        state_d      = S_EMIT;
      end

      // header offset = addr - header - base, modulo 2**32
      S_FREE_SUB1: begin
        alu_req.a   = ALU_W'(req_addr_q);
        alu_req.b   = ALU_W'(HEADER_BYTES);
        alu_req.sub = 1'b1;
        off_d       = alu_rsp.sum[ADDR_W-1:0];
        state_d     = S_FREE_SUB2;
      end

      S_FREE_SUB2: begin
        alu_req.a   = ALU_W'(off_q);
        alu_req.b   = ALU_W'(heap_base_q);
        alu_req.sub = 1'b1;
        off_d       = alu_rsp.sum[ADDR_W-1:0];
        state_d     = S_FREE_CHK;
      end

      S_FREE_CHK: begin
        alu_req.a   = ALU_W'(off_q);
        alu_req.b   = ALU_W'(bump_q);
        alu_req.sub = 1'b1;
        if (free_ok) begin
          ram_re  = 1'b1;
          state_d = S_FREE_PUSH;
        end else begin
          res_addr_d   = '0;
          res_status_d = ST_IGNORED;
          state_d      = S_EMIT;
        end
      end

      S_FREE_PUSH: begin
        ent_we       = 1'b1;
        ent_widx     = cnt_q[FREE_IDX_W-1:0];
        ent_woff     = off_q[FOFF_W-1:0];
        ent_wsize    = ram_rdata_q;
        cnt_d        = cnt_q + CNT_W'(1);
        res_addr_d   = '0;
        res_status_d = ST_FREED;
        state_d      = S_EMIT;
      end

      // hand over once the output register is free
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_addr_d   = res_addr_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      bump_q       <= '0;
      ptr_q        <= '0;
      out_valid_q  <= 1'b0;
      heap_base_q  <= HEAP_BASE_RST;
      heap_limit_q <= HEAP_LIMIT_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      bump_q      <= bump_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr_i)
          CFG_HEAP_BASE:  heap_base_q  <= cfg_wdata_i;
          CFG_HEAP_LIMIT: heap_limit_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_size_q   <= req_size_d;
    req_addr_q   <= req_addr_d;
    off_q        <= off_d;
    end_q        <= end_d;
    abs_q        <= abs_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
    if (ent_we) begin
      free_off_q[ent_widx]  <= ent_woff;
      free_size_q[ent_widx] <= ent_wsize;
    end
  end

  // Size store, registered read
  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      size_mem[ram_waddr] <= req_size_q;
    end
    if (ram_re) begin
      ram_rdata_q <= size_mem[ram_raddr];
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FREE_DEPTH))
    else $error("free count above list depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($stable(cnt_q) || (cnt_q == $past(cnt_q) + CNT_W'(1))
              || (cnt_q == $past(cnt_q) - CNT_W'(1))))
    else $error("free count moved by more than one");

  a_bump_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bump_q <= OFF_W'(HEAP_BYTES))
    && ((bump_q & OFF_W'(ALIGN_BYTES - 1)) == '0))
    else $error("bump offset past heap end or misaligned");

  a_bump_only_on_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bump_q != $past(bump_q)) |-> ($past(state_q) == S_BUMP_ADDR))
    else $error("bump offset changed outside a bump");

endmodule
